### src/ipv4gm_pkg.sv
`default_nettype none

package ipv4gm_pkg;

  // Table geometry
  localparam int PREFIX_SLOTS = 8;
  localparam int SLOT_W = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
  localparam int PREFIX_W = 16;
  localparam int LOW_W = 16;
  localparam int ENTRIES_PER_SLOT = 1 << LOW_W;
  localparam int STORE_DEPTH = PREFIX_SLOTS * ENTRIES_PER_SLOT;
  localparam int STORE_AW = SLOT_W + LOW_W;
  localparam int GROUP_W = 4;
  localparam int STATUS_W = 2;
  localparam int ADDR_W = 32;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNSET     = 2'd3;

  // Outcome of the prefix search for one item
  typedef struct packed {
    logic              found;  // a used slot holds the prefix
    logic              ok;     // insert has a slot (match or free)
    logic [SLOT_W-1:0] slot;   // slot the item addresses
  } slot_res_t;

endpackage

`default_nettype wire

### src/ipv4gm_if.sv
`default_nettype none

// Request channel: one lookup or insert per transfer
interface ipv4gm_req_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [ipv4gm_pkg::ADDR_W-1:0]      address;
  logic [ipv4gm_pkg::GROUP_W-1:0]     group_in;

  modport source (output valid, output opcode, output address, output group_in,
                  input ready);
  modport sink   (input valid, input opcode, input address, input group_in,
                  output ready);
endinterface

// Response channel: one result per request
interface ipv4gm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ipv4gm_pkg::STATUS_W-1:0]    status;
  logic [ipv4gm_pkg::GROUP_W-1:0]     group_out;

  modport source (output valid, output status, output group_out, input ready);
  modport sink   (input valid, input status, input group_out, output ready);
endinterface

`default_nettype wire

### src/ipv4gm_prefix_table.sv
`default_nettype none

module ipv4gm_prefix_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic                              opcode,
  input  wire logic [ipv4gm_pkg::PREFIX_W-1:0]   prefix,
  output ipv4gm_pkg::slot_res_t                  res
);

  logic [ipv4gm_pkg::PREFIX_SLOTS-1:0] used;
  logic [ipv4gm_pkg::PREFIX_W-1:0]     value [ipv4gm_pkg::PREFIX_SLOTS];
  logic [ipv4gm_pkg::PREFIX_SLOTS-1:0] match_vec;
  logic                                hit;
  logic [ipv4gm_pkg::SLOT_W-1:0]       hit_slot;
  logic                                has_free;
  logic [ipv4gm_pkg::SLOT_W-1:0]       free_slot;
  logic                                alloc;

  // Parallel compare against every used slot
  always_comb begin
    for (int s = 0; s < ipv4gm_pkg::PREFIX_SLOTS; s++) begin
      match_vec[s] = used[s] && (value[s] == prefix);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    has_free = 1'b0;
    free_slot = '0;
    for (int s = ipv4gm_pkg::PREFIX_SLOTS - 1; s >= 0; s--) begin
      if (match_vec[s]) begin
        hit = 1'b1;
        hit_slot = ipv4gm_pkg::SLOT_W'(s);
      end
      if (!used[s]) begin
        has_free = 1'b1;
        free_slot = ipv4gm_pkg::SLOT_W'(s);
      end
    end
  end

  assign res.found = hit;
  assign res.ok    = hit || has_free;
  assign res.slot  = hit ? hit_slot : free_slot;

  // New prefix takes the lowest free slot
  assign alloc = accept && (opcode == ipv4gm_pkg::OP_INSERT) && !hit && has_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (alloc) begin
      used[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      value[free_slot] <= prefix;
    end
  end

`ifndef ASSERT_OFF
  // Slots are never freed
  a_used_grows: assert property (@(posedge clk) disable iff (rst)
    ((used & $past(used)) == $past(used)))
    else $error("prefix slot freed");
  // A prefix is held by one used slot at most
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    ($countones(match_vec) <= 1))
    else $error("prefix held by several slots");
`endif

endmodule

`default_nettype wire

### src/ipv4gm_group_store.sv
`default_nettype none

module ipv4gm_group_store (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic                              rd_en,
  input  wire logic [ipv4gm_pkg::STORE_AW-1:0]   addr,
  input  wire logic [ipv4gm_pkg::GROUP_W-1:0]    wdata,
  output      logic [ipv4gm_pkg::GROUP_W-1:0]    rdata,
  output      logic                              busy
);

  logic [ipv4gm_pkg::GROUP_W-1:0]  mem [ipv4gm_pkg::STORE_DEPTH];
  logic                            clr_active;
  logic [ipv4gm_pkg::STORE_AW-1:0] clr_addr;
  logic                            mem_we;
  logic [ipv4gm_pkg::STORE_AW-1:0] mem_waddr;
  logic [ipv4gm_pkg::GROUP_W-1:0]  mem_wdata;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ipv4gm_pkg::STORE_AW'(ipv4gm_pkg::STORE_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign busy      = clr_active;
  assign mem_we    = clr_active || wr_en;
  assign mem_waddr = clr_active ? clr_addr : addr;
  assign mem_wdata = clr_active ? '0 : wdata;

  // Single write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

`ifndef ASSERT_OFF
  // Sweep ends only after the last entry
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |->
      ($past(clr_addr) == ipv4gm_pkg::STORE_AW'(ipv4gm_pkg::STORE_DEPTH - 1)))
    else $error("clear sweep ended early");
`endif

endmodule

`default_nettype wire

### src/ipv4_group_map_table.sv
// IPv4 to server group map.
// req channel (valid/ready): opcode (lookup or insert), address, group_in.
// rsp channel (valid/ready): status (ok, prefix not found, table full,
// entry unset) and group_out. Each request yields exactly one response.
// The upper 16 address bits are matched against a small prefix table in
// parallel; the slot and the lower 16 bits address a single-port group
// store with a registered read. Each request passes the lookup stage,
// then the output register.
// Throughput: one request per cycle while req.ready is high; inserts
// write the store at the transfer edge and lookups read it there, so
// no interlock is needed.
// Reset: every prefix slot is freed and a sweep clears the group store,
// one entry per cycle.
// req.ready stays low during the sweep.
// Stall: the response sits in an output register; with one more request
// held in the lookup stage, req.ready drops until rsp.ready returns.
`default_nettype none

module ipv4_group_map_table (
  input  wire logic      clk,
  input  wire logic      rst,
  ipv4gm_req_if.sink     req,
  ipv4gm_rsp_if.source   rsp
);

  ipv4gm_pkg::slot_res_t               sres;
  logic                                accept;
  logic                                is_insert;
  logic                                store_busy;
  logic                                wr_en;
  logic                                rd_en;
  logic [ipv4gm_pkg::STORE_AW-1:0]     store_addr;
  logic [ipv4gm_pkg::GROUP_W-1:0]      rdata;

  logic                                s1_valid;
  logic                                s1_lookup;
  logic                                s1_found;
  logic                                s1_ok;
  logic [ipv4gm_pkg::GROUP_W-1:0]      s1_group;
  logic                                s1_adv;
  logic [ipv4gm_pkg::STATUS_W-1:0]     s1_status;
  logic [ipv4gm_pkg::GROUP_W-1:0]      s1_gout;

  logic                                out_valid;
  logic [ipv4gm_pkg::STATUS_W-1:0]     out_status;
  logic [ipv4gm_pkg::GROUP_W-1:0]      out_group;
  logic                                out_free;

  // Handshake
  assign out_free  = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !store_busy && (!s1_valid || out_free);
  assign accept    = req.valid && req.ready;
  assign is_insert = (req.opcode == ipv4gm_pkg::OP_INSERT);

  ipv4gm_prefix_table u_prefix (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (req.opcode),
    .prefix (req.address[31:16]),
    .res    (sres)
  );

  // Store access at the transfer edge
  assign store_addr = {sres.slot, req.address[15:0]};
  assign wr_en      = accept && is_insert && sres.ok;
  assign rd_en      = accept && !is_insert && sres.found;

  ipv4gm_group_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .rd_en (rd_en),
    .addr  (store_addr),
    .wdata (req.group_in),
    .rdata (rdata),
    .busy  (store_busy)
  );

  // Lookup stage: waits for read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lookup <= !is_insert;
      s1_found  <= sres.found;
      s1_ok     <= sres.ok;
      s1_group  <= req.group_in;
    end
  end

  // Result selection
  always_comb begin
    s1_status = ipv4gm_pkg::ST_OK;
    s1_gout   = '0;
    if (s1_lookup) begin
      if (!s1_found) begin
        s1_status = ipv4gm_pkg::ST_NOT_FOUND;
      end else if (rdata == '0) begin
        s1_status = ipv4gm_pkg::ST_UNSET;
      end else begin
        s1_gout = rdata;
      end
    end else if (s1_ok) begin
      s1_gout = s1_group;
    end else begin
      s1_status = ipv4gm_pkg::ST_FULL;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status <= s1_status;
      out_group  <= s1_gout;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.group_out = out_group;

`ifndef ASSERT_OFF
  // A blocked lookup stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("lookup stage dropped an item");
  // Failed results never carry a group
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ipv4gm_pkg::ST_OK) |-> (out_group == '0))
    else $error("group on failed result");
  // No store write or read while the sweep runs
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !wr_en && !rd_en)
    else $error("store access during clear");
`endif

endmodule

`default_nettype wire
